// ----- design/srlm_pkg.sv -----
// Shared constants and types for the scroll region line map.
package srlm_pkg;

    localparam int MAX_ROWS_DEF = 64;

    localparam logic [3:0] FN_SCROLL_UP   = 4'd0;
    localparam logic [3:0] FN_SCROLL_DOWN = 4'd1;
    localparam logic [3:0] FN_INSERT      = 4'd2;
    localparam logic [3:0] FN_DELETE      = 4'd3;
    localparam logic [3:0] FN_LOOKUP      = 4'd4;
    localparam logic [3:0] FN_DIRTY       = 4'd5;
    localparam logic [3:0] FN_IMAGE       = 4'd6;
    localparam logic [3:0] FN_CLEAR_ATTR  = 4'd7;
    localparam logic [3:0] FN_WRAP        = 4'd8;

    localparam logic REG_ROWS_IN_USE = 1'b0;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CPR  = 9'b000000010,
        S_CPW  = 9'b000000100,
        S_WBR  = 9'b000001000,
        S_WBW  = 9'b000010000,
        S_PRV  = 9'b000100000,
        S_CUR  = 9'b001000000,
        S_UPD  = 9'b010000000,
        S_EMIT = 9'b100000000
    } state_t;

endpackage

// ----- design/srlm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/scroll_region_line_map.sv -----
// Top level of the scroll region line map: sequencer, stores and APB register.
//
// Usage: requests arrive on the s_ channel (valid/ready), results leave on the
// m_ channel (valid/ready). rows_in_use sits at APB address 0 and is to be
// written only while the block is idle; the block itself does not enforce this.
// Scroll, insert and delete copy the region [row, bottom] into a scratch RAM
// and write it back rotated; the copy pass reads through the single read port
// of the map RAM. Insert and delete emit one clear transfer per blanked row
// during the write-back pass, the final one marked with m_last. Lookups and
// flag writes pass through S_PRV (skipped for row 0), S_CUR, S_UPD and S_EMIT;
// ignored requests go straight to S_EMIT. s_ready is high only between items;
// a new request is taken once the previous item's last result has been loaded
// into the output register, so one result may wait there while the next item
// runs. When the receiver stalls the write-back pass holds on the pending clear.
// Reset (synchronous, aresetn low) returns the map to identity and all flags
// to zero at once through per-entry valid bits; no clearing pass is needed.
module scroll_region_line_map #(
    parameter int MAX_ROWS = srlm_pkg::MAX_ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_func,
    input  logic [5:0]  s_row,
    input  logic [5:0]  s_bottom,
    input  logic [6:0]  s_count,
    input  logic        s_flag_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_physical_line,
    output logic        m_row_dirty,
    output logic        m_row_has_image,
    output logic        m_row_continued,
    output logic        m_clear_request,
    output logic        m_ignored,
    output logic        m_last
);
    import srlm_pkg::*;

    localparam int AW = $clog2(MAX_ROWS);
    localparam int EW = AW + 2;
    localparam logic [6:0] MAXR = 7'(MAX_ROWS);

    // configuration
    logic [6:0] rows_reg;
    logic [6:0] wrows;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWS_IN_USE) ? {25'd0, rows_reg} : 32'd0;
    assign wrows  = (rows_reg > MAXR) ? MAXR : rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 7'd64;
        end else if (psel && penable && pwrite && paddr[2] == REG_ROWS_IN_USE) begin
            rows_reg <= pwdata[6:0];
        end
    end

    // item registers
    state_t     state_reg, state_next;
    logic [3:0] func_reg;
    logic [6:0] row_reg, lo_reg, hi_reg, i_reg, src_reg, start_reg;
    logic [6:0] clo_reg, chi_reg;
    logic       fv_reg, hasclr_reg;
    logic [5:0] p_line_reg;
    logic       p_dirty_reg, p_img_reg, p_cont_reg, p_ign_reg;

    // stores
    logic [EW-1:0]       map_wdata, map_rdata, scr_rdata, map_ent;
    logic [AW-1:0]       map_waddr, map_raddr, scr_raddr, wrap_waddr, wrap_raddr;
    logic                map_we, scr_we, wrap_we, wrap_wdata, wrap_rdata, wrap_bit;
    logic [MAX_ROWS-1:0] map_vld_reg, wrap_vld_reg;
    logic [AW-1:0]       map_ra_q;
    logic                map_vq, wrap_vq;

    srlm_ram #(.WIDTH(EW), .DEPTH(MAX_ROWS)) u_map (
        .aclk(aclk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );
    srlm_ram #(.WIDTH(EW), .DEPTH(MAX_ROWS)) u_scratch (
        .aclk(aclk), .we(scr_we), .waddr(i_reg[AW-1:0]), .wdata(map_ent),
        .raddr(scr_raddr), .rdata(scr_rdata)
    );
    srlm_ram #(.WIDTH(1), .DEPTH(MAX_ROWS)) u_wrap (
        .aclk(aclk), .we(wrap_we), .waddr(wrap_waddr), .wdata(wrap_wdata),
        .raddr(wrap_raddr), .rdata(wrap_rdata)
    );

    // entries never written read as the reset value
    assign map_ent  = map_vq ? map_rdata : {map_ra_q, 2'b00};
    assign wrap_bit = wrap_vq & wrap_rdata;

    always_ff @(posedge aclk) begin
        map_ra_q <= map_raddr;
        if (!aresetn) begin
            map_vld_reg  <= '0;
            wrap_vld_reg <= '0;
            map_vq       <= 1'b0;
            wrap_vq      <= 1'b0;
        end else begin
            map_vq  <= map_vld_reg[map_raddr] && !(map_we && map_waddr == map_raddr);
            wrap_vq <= wrap_vld_reg[wrap_raddr] && !(wrap_we && wrap_waddr == wrap_raddr);
            if (map_we) begin
                map_vld_reg[map_waddr] <= 1'b1;
            end
            if (wrap_we) begin
                wrap_vld_reg[wrap_waddr] <= 1'b1;
            end
        end
    end

    // request decode
    logic [6:0] d_row, d_hi, d_len, d_num, d_shift;
    logic       ok_scroll, ok_move, ok_addr;
    assign d_row = {1'b0, s_row};
    assign d_hi  = {1'b0, s_bottom} + 7'd1;
    assign d_len = d_hi - d_row;
    assign d_num = (s_count < d_len) ? s_count : d_len;
    assign ok_scroll = (s_func == FN_SCROLL_UP || s_func == FN_SCROLL_DOWN)
                       && s_row < s_bottom && {1'b0, s_bottom} < wrows;
    assign ok_move   = (s_func == FN_INSERT || s_func == FN_DELETE)
                       && s_row <= s_bottom && {1'b0, s_bottom} < wrows && d_num != 7'd0;
    assign ok_addr   = s_func >= FN_LOOKUP && s_func <= FN_WRAP && d_row < wrows;

    always_comb begin
        case (s_func)
            FN_SCROLL_UP:   d_shift = 7'd1;
            FN_SCROLL_DOWN: d_shift = d_len - 7'd1;
            FN_INSERT:      d_shift = d_len - d_num;
            default:        d_shift = (d_num == d_len) ? 7'd0 : d_num;
        endcase
    end

    logic out_free, clearing, at_end;
    assign out_free = !m_valid || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign clearing = hasclr_reg && i_reg >= clo_reg && i_reg < chi_reg;
    assign at_end   = (i_reg == hi_reg - 7'd1);

    // RAM addressing
    always_comb begin
        map_raddr  = i_reg[AW-1:0];
        scr_raddr  = src_reg[AW-1:0];
        wrap_raddr = map_ent[EW-1:2];
        map_we     = 1'b0;
        map_waddr  = i_reg[AW-1:0];
        map_wdata  = scr_rdata;
        scr_we     = 1'b0;
        wrap_we    = 1'b0;
        wrap_waddr = scr_rdata[EW-1:2];
        wrap_wdata = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (ok_scroll || ok_move) begin
                        state_next = S_CPR;
                    end else if (ok_addr) begin
                        state_next = (s_row == 6'd0) ? S_CUR : S_PRV;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_CPR: state_next = S_CPW;
            S_CPW: begin
                scr_we     = 1'b1;
                state_next = at_end ? S_WBR : S_CPR;
            end
            S_WBR: state_next = S_WBW;
            S_WBW: begin
                if (!clearing || out_free) begin
                    map_we = 1'b1;
                    if (clearing) begin
                        map_wdata = {scr_rdata[EW-1:2], 2'b00};
                        wrap_we   = 1'b1;
                    end
                    if (at_end) begin
                        state_next = hasclr_reg ? S_IDLE : S_EMIT;
                    end else begin
                        state_next = S_WBR;
                    end
                end
            end
            S_PRV: begin
                map_raddr  = AW'(row_reg - 7'd1);
                state_next = S_CUR;
            end
            S_CUR: begin
                map_raddr  = row_reg[AW-1:0];
                state_next = S_UPD;
            end
            S_UPD: begin
                map_raddr = row_reg[AW-1:0];
                map_waddr = row_reg[AW-1:0];
                case (func_reg)
                    FN_DIRTY: begin
                        map_we    = 1'b1;
                        map_wdata = {map_ent[EW-1:2], fv_reg, map_ent[0]};
                    end
                    FN_IMAGE: begin
                        map_we    = 1'b1;
                        map_wdata = {map_ent[EW-1:1], fv_reg};
                    end
                    FN_CLEAR_ATTR: begin
                        map_we    = 1'b1;
                        map_wdata = {map_ent[EW-1:2], 2'b10};
                    end
                    FN_WRAP: begin
                        wrap_we    = 1'b1;
                        wrap_waddr = map_ent[EW-1:2];
                        wrap_wdata = fv_reg;
                    end
                    default: ;
                endcase
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            if ((state_reg == S_WBW && clearing && out_free)
                || (state_reg == S_EMIT && out_free)) begin
                m_valid <= 1'b1;
            end
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                func_reg   <= s_func;
                row_reg    <= d_row;
                fv_reg     <= s_flag_value;
                lo_reg     <= d_row;
                hi_reg     <= d_hi;
                i_reg      <= d_row;
                start_reg  <= d_row + d_shift;
                hasclr_reg <= (s_func == FN_INSERT || s_func == FN_DELETE);
                clo_reg    <= (s_func == FN_INSERT) ? d_row : d_hi - d_num;
                chi_reg    <= (s_func == FN_INSERT) ? d_row + d_num : d_hi;
                p_line_reg  <= 6'd0;
                p_dirty_reg <= 1'b0;
                p_img_reg   <= 1'b0;
                p_cont_reg  <= 1'b0;
                p_ign_reg   <= !(ok_scroll || ok_move || ok_addr);
            end
            S_CPW: begin
                if (at_end) begin
                    i_reg   <= lo_reg;
                    src_reg <= start_reg;
                end else begin
                    i_reg <= i_reg + 7'd1;
                end
            end
            S_WBW: begin
                if (!clearing || out_free) begin
                    i_reg   <= i_reg + 7'd1;
                    src_reg <= (src_reg == hi_reg - 7'd1) ? lo_reg : src_reg + 7'd1;
                end
            end
            S_UPD: begin
                if (func_reg == FN_LOOKUP) begin
                    p_line_reg  <= 6'(map_ent[EW-1:2]);
                    p_dirty_reg <= map_ent[1];
                    p_img_reg   <= map_ent[0];
                    p_cont_reg  <= (row_reg != 7'd0) && wrap_bit;
                end
            end
            default: ;
        endcase
    end

    // load the output register: a clear transfer during write-back, or the item's result in S_EMIT
    always_ff @(posedge aclk) begin
        if (state_reg == S_WBW && clearing && out_free) begin
            m_physical_line <= 6'(scr_rdata[EW-1:2]);
            m_row_dirty     <= 1'b0;
            m_row_has_image <= 1'b0;
            m_row_continued <= 1'b0;
            m_clear_request <= 1'b1;
            m_ignored       <= 1'b0;
            m_last          <= (i_reg + 7'd1 == chi_reg);
        end else if (state_reg == S_EMIT && out_free) begin
            m_physical_line <= p_line_reg;
            m_row_dirty     <= p_dirty_reg;
            m_row_has_image <= p_img_reg;
            m_row_continued <= p_cont_reg;
            m_clear_request <= 1'b0;
            m_ignored       <= p_ign_reg;
            m_last          <= 1'b1;
        end
    end
endmodule
